@@ rtl/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants and types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_CONJ  = 4'd4;
  localparam logic [3:0] OP_SCALE = 4'd5;
  localparam logic [3:0] OP_INV   = 4'd6;
  localparam logic [3:0] OP_MAGSQ = 4'd7;
  localparam logic [3:0] OP_MAG   = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_DIV  = 2'd1;
  localparam logic [1:0] KIND_SQRT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       neg_re;
    logic       neg_im;
  } cell_ctl_t;

endpackage

@@ rtl/cau_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: opcode and two complex operands.
// ----------------------------------------------------------------------------
interface cau_in_if #(
  parameter int DW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [3:0]           opcode;
  logic signed [DW-1:0] a_re;
  logic signed [DW-1:0] a_im;
  logic signed [DW-1:0] b_re;
  logic signed [DW-1:0] b_im;

  modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

@@ rtl/cau_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and status.
// ----------------------------------------------------------------------------
interface cau_out_if #(
  parameter int DW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] res_re;
  logic signed [DW-1:0] res_im;
  logic [1:0]           status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

@@ rtl/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU in signed fixed point with saturation and status.
// ----------------------------------------------------------------------------
// Takes one item per clock unless a stalled result port fills the pipeline,
// and returns one result per item, in order. Every item walks the same
// pipeline of DW + 5 stages: products, sums, rounding/setup, a chain of
// DW + 1 cells that each form one quotient bit of both divide parts (all
// but the first also one bit of the square root), then the output register.
// Each stage advances when the stage after it is empty or moving, so
// bubbles close up while the result port is stalled.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic    clk,
  input logic    rst,
  cau_in_if.sink operand,
  cau_out_if.source result
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int NW = 2 * DW + 2 * FB + 1;
  localparam int NC = DW + 1;

  logic                 v_c   [0:NC];
  logic                 en_c  [0:NC];
  cell_ctl_t            ctl_c [0:NC];
  logic [2*DW-1:0]      den_c [0:NC];
  logic [NW-1:0]        rre_c [0:NC];
  logic [NW-1:0]        rim_c [0:NC];
  logic [DW:0]          qre_c [0:NC];
  logic [DW:0]          qim_c [0:NC];
  logic [2*DW-1:0]      srem_c[0:NC];
  logic [DW-1:0]        root_c[0:NC];
  logic signed [DW-1:0] fre_c [0:NC];
  logic signed [DW-1:0] fim_c [0:NC];
  logic [1:0]           fst_c [0:NC];

  logic rdyf;

  cau_front #(.DW(DW), .FB(FB)) u_front (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand),
    .out_valid (v_c[0]),
    .out_en    (en_c[0]),
    .ctl       (ctl_c[0]),
    .den       (den_c[0]),
    .rre       (rre_c[0]),
    .rim       (rim_c[0]),
    .srem      (srem_c[0]),
    .res_re    (fre_c[0]),
    .res_im    (fim_c[0]),
    .status    (fst_c[0])
  );

  assign qre_c[0]  = '0;
  assign qim_c[0]  = '0;
  assign root_c[0] = '0;
  assign en_c[NC]  = rdyf;

  genvar i;
  generate
    for (i = 0; i < NC; i++) begin : g_cell
      assign en_c[i] = !v_c[i+1] || en_c[i+1];
      cau_cell #(.DW(DW), .FB(FB), .K(DW - i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .en         (en_c[i]),
        .vin        (v_c[i]),
        .vout       (v_c[i+1]),
        .ctl_in     (ctl_c[i]),
        .ctl_out    (ctl_c[i+1]),
        .den_in     (den_c[i]),
        .den_out    (den_c[i+1]),
        .rre_in     (rre_c[i]),
        .rre_out    (rre_c[i+1]),
        .rim_in     (rim_c[i]),
        .rim_out    (rim_c[i+1]),
        .qre_in     (qre_c[i]),
        .qre_out    (qre_c[i+1]),
        .qim_in     (qim_c[i]),
        .qim_out    (qim_c[i+1]),
        .srem_in    (srem_c[i]),
        .srem_out   (srem_c[i+1]),
        .root_in    (root_c[i]),
        .root_out   (root_c[i+1]),
        .res_re_in  (fre_c[i]),
        .res_re_out (fre_c[i+1]),
        .res_im_in  (fim_c[i]),
        .res_im_out (fim_c[i+1]),
        .status_in  (fst_c[i]),
        .status_out (fst_c[i+1])
      );
    end
  endgenerate

  localparam logic [DW:0] TOPQ = (DW+1)'(1) << (DW - 1);

  function automatic logic [DW:0] clamp_q(input logic [DW:0] q, input logic neg);
    logic [DW:0] r;
    logic [DW:0] nq;
    nq = ~q + (DW+1)'(1);
    if (neg && q != '0) begin
      if (q > TOPQ) begin
        r = {1'b1, 1'b1, {(DW-1){1'b0}}};
      end else begin
        r = {1'b0, nq[DW-1:0]};
      end
    end else if (q > TOPQ - (DW+1)'(1)) begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else begin
      r = {1'b0, q[DW-1:0]};
    end
    return r;
  endfunction

  cell_ctl_t     lc;
  logic [DW:0]   cq_re, cq_im, cr;
  logic [DW-1:0] out_re_n, out_im_n;
  logic [1:0]    out_st_n;

  always_comb begin
    lc       = ctl_c[NC];
    cq_re    = clamp_q(qre_c[NC], lc.neg_re);
    cq_im    = clamp_q(qim_c[NC], lc.neg_im);
    cr       = clamp_q({1'b0, root_c[NC]}, 1'b0);
    out_re_n = fre_c[NC];
    out_im_n = fim_c[NC];
    out_st_n = fst_c[NC];
    case (lc.kind)
      KIND_DIV: begin
        out_re_n = cq_re[DW-1:0];
        out_im_n = cq_im[DW-1:0];
        out_st_n = (cq_re[DW] | cq_im[DW]) ? ST_SAT : ST_OK;
      end
      KIND_SQRT: begin
        out_re_n = cr[DW-1:0];
        out_im_n = '0;
        out_st_n = cr[DW] ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign rdyf = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rdyf) begin
      result.valid <= v_c[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (rdyf) begin
      result.res_re <= out_re_n;
      result.res_im <= out_im_n;
      result.status <= out_st_n;
    end
  end

endmodule

@@ rtl/cau_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Three front stages: products, sums, then rounding and divider/root setup.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
#(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  cau_in_if.sink               operand,
  output logic                 out_valid,
  input  logic                 out_en,
  output cell_ctl_t            ctl,
  output logic [2*DW-1:0]      den,
  output logic [2*DW+2*FB:0]   rre,
  output logic [2*DW+2*FB:0]   rim,
  output logic [2*DW-1:0]      srem,
  output logic signed [DW-1:0] res_re,
  output logic signed [DW-1:0] res_im,
  output logic [1:0]           status
);

  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + FB + 1;
  localparam int NW = SW + FB;

  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FB - 1);

  function automatic logic [DW:0] clamp_sw(input logic signed [SW-1:0] v);
    logic [DW:0] r;
    if (v > SMAX) begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else if (v < SMIN) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  logic rdy1, rdy2, rdy3;
  logic v1, v2;

  assign rdy3 = !out_valid || out_en;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign operand.ready = rdy1;

  // stage 1: products
  logic [3:0]           op1;
  logic signed [DW-1:0] ar1, ai1, br1, bi1;
  logic signed [PW-1:0] pa, pb, pc, pd, pdr, pdi;
  logic signed [DW-1:0] dr, di;

  always_comb begin
    if (operand.opcode == OP_DIV) begin
      dr = operand.b_re;
      di = operand.b_im;
    end else begin
      dr = operand.a_re;
      di = operand.a_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= operand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1 <= operand.opcode;
      ar1 <= operand.a_re;
      ai1 <= operand.a_im;
      br1 <= operand.b_re;
      bi1 <= operand.b_im;
      pa  <= PW'(operand.a_re) * PW'(operand.b_re);
      pb  <= PW'(operand.a_im) * PW'(operand.b_im);
      pc  <= PW'(operand.a_re) * PW'(operand.b_im);
      pd  <= PW'(operand.a_im) * PW'(operand.b_re);
      pdr <= PW'(dr) * PW'(dr);
      pdi <= PW'(di) * PW'(di);
    end
  end

  // stage 2: sums
  logic [3:0]           op2;
  logic signed [SW-1:0] s_re, s_im, s_re2, s_im2, dsum;
  logic [DW:0]          fre, fim;
  logic [DW-1:0]        fin_re2, fin_im2;
  logic                 fin_sat2;
  logic [PW-1:0]        den2;

  always_comb begin
    dsum = SW'(pdr) + SW'(pdi);
    s_re = '0;
    s_im = '0;
    fre  = '0;
    fim  = '0;
    case (op1)
      OP_ADD: begin
        fre = clamp_sw(SW'(ar1) + SW'(br1));
        fim = clamp_sw(SW'(ai1) + SW'(bi1));
      end
      OP_SUB: begin
        fre = clamp_sw(SW'(ar1) - SW'(br1));
        fim = clamp_sw(SW'(ai1) - SW'(bi1));
      end
      OP_CONJ: begin
        fre = {1'b0, ar1};
        fim = clamp_sw(-SW'(ai1));
      end
      OP_MUL: begin
        s_re = SW'(pa) - SW'(pb);
        s_im = SW'(pc) + SW'(pd);
      end
      OP_DIV: begin
        s_re = SW'(pa) + SW'(pb);
        s_im = SW'(pd) - SW'(pc);
      end
      OP_SCALE: begin
        s_re = SW'(pa);
        s_im = SW'(pd);
      end
      OP_INV: begin
        s_re = SW'(ar1) <<< FB;
        s_im = -(SW'(ai1) <<< FB);
      end
      OP_MAGSQ, OP_MAG: begin
        s_re = dsum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      op2      <= op1;
      s_re2    <= s_re;
      s_im2    <= s_im;
      den2     <= dsum[PW-1:0];
      fin_re2  <= fre[DW-1:0];
      fin_im2  <= fim[DW-1:0];
      fin_sat2 <= fre[DW] | fim[DW];
    end
  end

  // stage 3: rounding, divider and root setup
  logic signed [SW-1:0] rnd_re, rnd_im;
  logic [DW:0]          cre, cim;
  logic [SW-1:0]        m_re, m_im;
  cell_ctl_t            ctl_n;
  logic [DW-1:0]        res_re_n, res_im_n;
  logic [1:0]           status_n;

  always_comb begin
    rnd_re   = (s_re2 + HALF) >>> FB;
    rnd_im   = (s_im2 + HALF) >>> FB;
    cre      = clamp_sw(rnd_re);
    cim      = clamp_sw(rnd_im);
    m_re     = s_re2[SW-1] ? SW'(-s_re2) : SW'(s_re2);
    m_im     = s_im2[SW-1] ? SW'(-s_im2) : SW'(s_im2);
    ctl_n    = '{kind: KIND_DONE, neg_re: s_re2[SW-1], neg_im: s_im2[SW-1]};
    res_re_n = '0;
    res_im_n = '0;
    status_n = ST_OK;
    case (op2)
      OP_ADD, OP_SUB, OP_CONJ: begin
        res_re_n = fin_re2;
        res_im_n = fin_im2;
        status_n = fin_sat2 ? ST_SAT : ST_OK;
      end
      OP_MUL, OP_SCALE, OP_MAGSQ: begin
        res_re_n = cre[DW-1:0];
        res_im_n = cim[DW-1:0];
        status_n = (cre[DW] | cim[DW]) ? ST_SAT : ST_OK;
      end
      OP_DIV, OP_INV: begin
        if (den2 == '0) begin
          status_n = ST_DIV0;
        end else begin
          ctl_n.kind = KIND_DIV;
        end
      end
      OP_MAG: begin
        ctl_n.kind = KIND_SQRT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ctl    <= ctl_n;
      den    <= den2;
      rre    <= NW'(m_re) << FB;
      rim    <= NW'(m_im) << FB;
      srem   <= den2;
      res_re <= res_re_n;
      res_im <= res_im_n;
      status <= status_n;
    end
  end

endmodule

@@ rtl/cau_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_cell
// One step of the divider and root chain: a restoring quotient bit for
// both parts and, when K < DW, one root bit, registered.
// ----------------------------------------------------------------------------
module cau_cell
  import cau_pkg::*;
#(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int K  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vin,
  output logic                 vout,
  input  cell_ctl_t            ctl_in,
  output cell_ctl_t            ctl_out,
  input  logic [2*DW-1:0]      den_in,
  output logic [2*DW-1:0]      den_out,
  input  logic [2*DW+2*FB:0]   rre_in,
  output logic [2*DW+2*FB:0]   rre_out,
  input  logic [2*DW+2*FB:0]   rim_in,
  output logic [2*DW+2*FB:0]   rim_out,
  input  logic [DW:0]          qre_in,
  output logic [DW:0]          qre_out,
  input  logic [DW:0]          qim_in,
  output logic [DW:0]          qim_out,
  input  logic [2*DW-1:0]      srem_in,
  output logic [2*DW-1:0]      srem_out,
  input  logic [DW-1:0]        root_in,
  output logic [DW-1:0]        root_out,
  input  logic signed [DW-1:0] res_re_in,
  output logic signed [DW-1:0] res_re_out,
  input  logic signed [DW-1:0] res_im_in,
  output logic signed [DW-1:0] res_im_out,
  input  logic [1:0]           status_in,
  output logic [1:0]           status_out
);

  localparam int NW = 2 * DW + 2 * FB + 1;
  localparam int CW = (NW > 3 * DW + 1) ? NW : 3 * DW + 1;
  localparam int RW = 2 * DW + 1;

  logic [CW-1:0]  dk, cre, cim;
  logic [NW-1:0]  rre_n, rim_n;
  logic [DW:0]    qre_n, qim_n;
  logic [2*DW-1:0] srem_n;
  logic [DW-1:0]  root_n;

  always_comb begin
    dk    = CW'(den_in) << K;
    cre   = CW'(rre_in);
    cim   = CW'(rim_in);
    rre_n = rre_in;
    rim_n = rim_in;
    qre_n = qre_in;
    qim_n = qim_in;
    if (cre >= dk) begin
      rre_n = NW'(cre - dk);
      qre_n = qre_in | ((DW+1)'(1) << K);
    end
    if (cim >= dk) begin
      rim_n = NW'(cim - dk);
      qim_n = qim_in | ((DW+1)'(1) << K);
    end
  end

  generate
    if (K < DW) begin : g_root
      logic [RW-1:0] trial;
      always_comb begin
        trial  = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));
        srem_n = srem_in;
        root_n = root_in;
        if (RW'(srem_in) >= trial) begin
          srem_n = srem_in - trial[2*DW-1:0];
          root_n = root_in | (DW'(1) << K);
        end
      end
    end else begin : g_no_root
      assign srem_n = srem_in;
      assign root_n = root_in;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out    <= ctl_in;
      den_out    <= den_in;
      rre_out    <= rre_n;
      rim_out    <= rim_n;
      qre_out    <= qre_n;
      qim_out    <= qim_n;
      srem_out   <= srem_n;
      root_out   <= root_n;
      res_re_out <= res_re_in;
      res_im_out <= res_im_in;
      status_out <= status_in;
    end
  end

endmodule
